FILE: rtl/core/pzq_pkg.sv
// Shared types and constants of the polygon zone query unit.
package pzq_pkg;

   localparam int MAX_ZONES_DEF    = 8;
   localparam int MAX_VERTICES_DEF = 16;
   localparam logic [15:0] DEFAULT_SPEED = 16'd300;
   localparam logic [15:0] SPEED_NONE    = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZONE,
      ST_LOADP,
      ST_DIFF,
      ST_MULP,
      ST_MULQ,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/polygon_zone_query_unit.sv
// Polygon zone table with even-odd point queries over one shared multiplier.
// Writes: result strobe in the cycle after accept, busy stays low (one item per cycle while no query holds busy).
// Query: walks the zones (ZONE, then for a zone of n >= 3 vertices LOADP and DIFF, MULP, MULQ, CMP
//   per edge), then DONE and the result strobe; busy until then.
// The receiver cannot stall; results are strobed for one cycle.
// Reset (synchronous) clears zone headers and control; vertex RAM is undefined until written.
module polygon_zone_query_unit
   import pzq_pkg::*;
#(
   parameter int MAX_ZONES    = MAX_ZONES_DEF,
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_zone_index,
   input  logic [3:0]         req_vertex_index,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic               req_zone_kind,
   input  logic [15:0]        req_speed_value,
   input  logic [4:0]         req_vertex_count,
   output logic               rsp_valid,
   output logic               rsp_is_query_result,
   output logic               rsp_forbidden_hit,
   output logic               rsp_speed_hit,
   output logic [15:0]        rsp_min_speed
);

   localparam int DEPTH = MAX_ZONES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int ZIW   = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int VW    = $clog2(MAX_VERTICES);

   state_type state_ff, state_in;

   logic [63:0] vmem [DEPTH];
   logic [63:0] rd_ff;
   logic [AW-1:0] rd_addr;

   logic              ztype_ff  [MAX_ZONES];
   logic [15:0]       zspeed_ff [MAX_ZONES];
   logic [4:0]        zsize_ff  [MAX_ZONES];

   logic signed [31:0] qx_ff, qy_ff;
   logic [ZIW-1:0]     zone_ff;
   logic [AW-1:0]      base_ff;
   logic [VW-1:0]      idx_ff;
   logic signed [31:0] px_ff, py_ff, cx_ff, cy_ff;
   logic               cross_ff, pn_ff, qn_ff, inside_ff;
   logic [31:0]        ma_ff, mb_ff, mc_ff, md_ff;
   logic [63:0]        pm_ff, qm_ff;
   logic               fhit_ff, shit_ff;
   logic [15:0]        best_ff;

   logic               rsp_valid_ff, rsp_query_ff, rsp_fhit_ff, rsp_shit_ff;
   logic [15:0]        rsp_speed_ff;

   logic        accept;
   kind_type    kind;
   logic [4:0]  cur_size;
   logic        zone_skip, zone_last, edge_last, less;
   logic [63:0] product;
   logic [31:0] mul_a, mul_b;
   logic signed [32:0] dxp, dxe, dyp, dd;
   logic        pn_eff, qn_eff;
   logic [63:0] wr_data;
   logic        wr_vertex, wr_header;
   logic signed [31:0] cx_in_x, cy_in_y;

   assign accept    = start && !busy;
   assign kind      = kind_type'(req_kind);
   assign busy      = (state_ff != ST_IDLE);
   assign cur_size  = zsize_ff[zone_ff];
   assign zone_skip = (cur_size < 5'd3);
   assign zone_last = (32'(zone_ff) == MAX_ZONES - 1);
   assign edge_last = (32'(idx_ff) == 32'(cur_size) - 1);

   assign wr_vertex = accept && (kind == KIND_VERTEX) && (32'(req_zone_index) < MAX_ZONES)
                      && (32'(req_vertex_index) < MAX_VERTICES);
   assign wr_header = accept && (kind == KIND_HEADER) && (32'(req_zone_index) < MAX_ZONES);
   assign wr_data   = {req_x_coord, req_y_coord};

   // Edge differences from previous (j) and current (i) vertex
   always_comb begin
      cx_in_x = $signed(rd_ff[63:32]);
      cy_in_y = $signed(rd_ff[31:0]);
   end
   assign dd  = 33'(py_ff) - 33'(cy_in_y);
   assign dxp = 33'(qx_ff) - 33'(cx_in_x);
   assign dxe = 33'(px_ff) - 33'(cx_in_x);
   assign dyp = 33'(qy_ff) - 33'(cy_in_y);

   // Shared multiplier
   assign mul_a   = (state_ff == ST_MULP) ? ma_ff : mc_ff;
   assign mul_b   = (state_ff == ST_MULP) ? mb_ff : md_ff;
   assign product = 64'(mul_a) * 64'(mul_b);

   // Signed compare in sign-magnitude form, zero counts as positive
   always_comb begin
      pn_eff = pn_ff && (pm_ff != 64'd0);
      qn_eff = qn_ff && (qm_ff != 64'd0);
      if (pn_eff != qn_eff) begin
         less = pn_eff;
      end else if (pn_eff) begin
         less = (pm_ff > qm_ff);
      end else begin
         less = (pm_ff < qm_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind == KIND_QUERY) state_in = ST_ZONE;
         end
         ST_ZONE: begin
            if (!zone_skip)     state_in = ST_LOADP;
            else if (zone_last) state_in = ST_DONE;
         end
         ST_LOADP: state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MULP;
         ST_MULP:  state_in = ST_MULQ;
         ST_MULQ:  state_in = ST_CMP;
         ST_CMP: begin
            if (!edge_last)     state_in = ST_DIFF;
            else if (zone_last) state_in = ST_DONE;
            else                state_in = ST_ZONE;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_addr = base_ff + AW'(idx_ff);
      unique case (state_ff)
         ST_ZONE:  rd_addr = base_ff + AW'(cur_size - 5'd1);
         ST_CMP:   rd_addr = base_ff + AW'(idx_ff) + AW'(1);
         default:  rd_addr = base_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_vertex) begin
         vmem[AW'(32'(req_zone_index) * MAX_VERTICES + 32'(req_vertex_index))] <= wr_data;
      end
      rd_ff <= vmem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int z = 0; z < MAX_ZONES; z++) begin
            ztype_ff[z]  <= 1'b0;
            zspeed_ff[z] <= 16'd0;
            zsize_ff[z]  <= 5'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (accept && kind != KIND_QUERY) || (state_ff == ST_DONE);
         if (wr_header) begin
            ztype_ff[ZIW'(req_zone_index)]  <= req_zone_kind;
            zspeed_ff[ZIW'(req_zone_index)] <= (req_speed_value == 16'd0) ? DEFAULT_SPEED
                                                                          : req_speed_value;
            zsize_ff[ZIW'(req_zone_index)]  <= (32'(req_vertex_count) > MAX_VERTICES)
                                               ? 5'(MAX_VERTICES) : req_vertex_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_query_ff <= (state_ff == ST_DONE);
      rsp_fhit_ff  <= (state_ff == ST_DONE) && fhit_ff;
      rsp_shit_ff  <= (state_ff == ST_DONE) && shit_ff;
      rsp_speed_ff <= (state_ff == ST_DONE && shit_ff) ? best_ff : 16'd0;

      unique case (state_ff)
         ST_IDLE: begin
            qx_ff   <= req_x_coord;
            qy_ff   <= req_y_coord;
            zone_ff <= '0;
            base_ff <= '0;
            fhit_ff <= 1'b0;
            shit_ff <= 1'b0;
            best_ff <= SPEED_NONE;
         end
         ST_ZONE: begin
            inside_ff <= 1'b0;
            idx_ff    <= '0;
            if (zone_skip) begin
               zone_ff <= zone_ff + ZIW'(1);
               base_ff <= base_ff + AW'(MAX_VERTICES);
            end
         end
         ST_LOADP: begin
            px_ff <= $signed(rd_ff[63:32]);
            py_ff <= $signed(rd_ff[31:0]);
         end
         ST_DIFF: begin
            cx_ff    <= cx_in_x;
            cy_ff    <= cy_in_y;
            cross_ff <= (cy_in_y > qy_ff) != (py_ff > qy_ff);
            pn_ff    <= dxp[32];
            qn_ff    <= dxe[32] ^ dyp[32] ^ dd[32];
            ma_ff    <= dxp[32] ? 32'(-dxp) : dxp[31:0];
            mb_ff    <= dd[32]  ? 32'(-dd)  : dd[31:0];
            mc_ff    <= dxe[32] ? 32'(-dxe) : dxe[31:0];
            md_ff    <= dyp[32] ? 32'(-dyp) : dyp[31:0];
         end
         ST_MULP: pm_ff <= product;
         ST_MULQ: qm_ff <= product;
         ST_CMP: begin
            px_ff <= cx_ff;
            py_ff <= cy_ff;
            idx_ff <= idx_ff + VW'(1);
            if (edge_last) begin
               // close the zone: fold its parity into the hit flags
               if (inside_ff ^ (cross_ff && less)) begin
                  if (!ztype_ff[zone_ff]) begin
                     fhit_ff <= 1'b1;
                  end else begin
                     shit_ff <= 1'b1;
                     if (zspeed_ff[zone_ff] < best_ff) best_ff <= zspeed_ff[zone_ff];
                  end
               end
               zone_ff <= zone_ff + ZIW'(1);
               base_ff <= base_ff + AW'(MAX_VERTICES);
            end else begin
               inside_ff <= inside_ff ^ (cross_ff && less);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_query_result = rsp_query_ff;
   assign rsp_forbidden_hit   = rsp_fhit_ff;
   assign rsp_speed_hit       = rsp_shit_ff;
   assign rsp_min_speed       = rsp_speed_ff;

endmodule
